// File: rtl/sks_pkg.sv
// sks_pkg: shared constants and types for the sorted key node search block.
// No dependencies.
package sks_pkg;

    localparam int CAPACITY = 512;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int CHILD_W  = 31;
    localparam int POS_W    = 9;
    localparam int COUNT_W  = 10;
    localparam int SLOT_W   = 9;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_SEARCH = 2'd2,
        REQ_READ   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_RANGE    = 2'd3
    } status_t;

    // Map float bits to an unsigned value that sorts in numeric order.
    function automatic logic [KEY_W-1:0] order_key(input logic [KEY_W-1:0] bits);
        logic [KEY_W-1:0] b;
        b = (bits == 32'h8000_0000) ? '0 : bits;
        if (b[KEY_W-1]) begin
            return ~b;
        end
        return b | 32'h8000_0000;
    endfunction

endpackage

// File: rtl/sks_ram.sv
// sks_ram: generic single-port RAM with registered read.
// No dependencies.
module sks_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// File: rtl/sorted_key_node_search_top.sv
// sorted_key_node_search_top: B-tree node store with predecessor binary search.
// Depends on sks_pkg and sks_ram.
//
// Channel | Dir | Ports
// s_      | in  | s_valid s_ready s_req_type s_key s_child_in s_slot_index
// m_      | out | m_valid m_ready m_status m_position m_child_out m_count m_full_res
//
// Path from accept to m_valid: clear/append go to S_OUT, read passes S_CHILD, and a
// search passes S_FIRST, S_PROBE/S_CMP for each of ceil(log2(count)) probes, S_CHILD.
// A search below the first key ends after S_FIRST, one on an empty node goes to S_OUT.
// Reset clears the entry count and control; RAM contents are undefined until written.
// One beat in processing; s_ready follows the idle state, so a new beat is taken
// while the previous result still waits in the output register. A finished beat
// holds in S_OUT until the output register is free.
module sorted_key_node_search_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_req_type,
    input  logic [sks_pkg::KEY_W-1:0]   s_key,
    input  logic [sks_pkg::CHILD_W-1:0] s_child_in,
    input  logic [sks_pkg::SLOT_W-1:0]  s_slot_index,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_status,
    output logic [sks_pkg::POS_W-1:0]   m_position,
    output logic [sks_pkg::CHILD_W-1:0] m_child_out,
    output logic [sks_pkg::COUNT_W-1:0] m_count,
    output logic                        m_full_res
);
    localparam int IW      = sks_pkg::IDX_W;
    localparam int CW      = sks_pkg::CNT_W;
    localparam int COUNT_W = sks_pkg::COUNT_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FIRST = 6'b000010,  // key[0] read pending
        S_PROBE = 6'b000100,  // issue mid read
        S_CMP   = 6'b001000,  // mid key back
        S_CHILD = 6'b010000,  // child read pending
        S_OUT   = 6'b100000
    } state_t;

    state_t                      state_reg, state_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [IW-1:0]               lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic [sks_pkg::KEY_W-1:0]   k_reg, k_next;
    logic [1:0]                  st_reg, st_next;
    logic [sks_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [sks_pkg::CHILD_W-1:0] cout_reg, cout_next;
    logic                        valid_reg, valid_next;

    // output register, loaded when a beat finishes
    logic [1:0]                  out_st_reg, out_st_next;
    logic [sks_pkg::POS_W-1:0]   out_pos_reg, out_pos_next;
    logic [sks_pkg::CHILD_W-1:0] out_cout_reg, out_cout_next;
    logic [COUNT_W-1:0]          out_count_reg, out_count_next;
    logic                        out_full_reg, out_full_next;

    logic                        ram_we;
    logic [IW-1:0]               ram_addr;
    logic [sks_pkg::KEY_W-1:0]   key_rd;
    logic [sks_pkg::CHILD_W-1:0] child_rd;
    logic [IW:0]                 mid_sum;

    sks_ram #(.WIDTH(sks_pkg::KEY_W), .DEPTH(sks_pkg::CAPACITY)) u_key_ram (
        .aclk(aclk), .we(ram_we), .addr(ram_addr), .wdata(s_key), .rdata(key_rd));
    sks_ram #(.WIDTH(sks_pkg::CHILD_W), .DEPTH(sks_pkg::CAPACITY)) u_child_ram (
        .aclk(aclk), .we(ram_we), .addr(ram_addr), .wdata(s_child_in), .rdata(child_rd));

    assign s_ready     = (state_reg == S_IDLE);
    assign m_valid     = valid_reg;
    assign m_status    = out_st_reg;
    assign m_position  = out_pos_reg;
    assign m_child_out = out_cout_reg;
    assign m_count     = out_count_reg;
    assign m_full_res  = out_full_reg;

    // upper midpoint of [lo, hi]
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} + {{IW{1'b0}}, 1'b1};

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        k_next         = k_reg;
        st_next        = st_reg;
        pos_next       = pos_reg;
        cout_next      = cout_reg;
        valid_next     = valid_reg;
        out_st_next    = out_st_reg;
        out_pos_next   = out_pos_reg;
        out_cout_next  = out_cout_reg;
        out_count_next = out_count_reg;
        out_full_next  = out_full_reg;
        ram_we         = 1'b0;
        ram_addr       = mid_reg;

        if (valid_reg && m_ready) begin
            valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                ram_addr = IW'(count_reg);
                if (s_valid && s_ready) begin
                    st_next   = sks_pkg::ST_OK;
                    pos_next  = '0;
                    cout_next = '0;
                    k_next    = sks_pkg::order_key(s_key);
                    case (s_req_type)
                        sks_pkg::REQ_CLEAR: begin
                            count_next = '0;
                            state_next = S_OUT;
                        end
                        sks_pkg::REQ_APPEND: begin
                            if (count_reg >= CW'(sks_pkg::CAPACITY)) begin
                                st_next = sks_pkg::ST_FULL;
                            end else begin
                                ram_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                            state_next = S_OUT;
                        end
                        sks_pkg::REQ_SEARCH: begin
                            ram_addr = '0;
                            if (count_reg == '0) begin
                                st_next    = sks_pkg::ST_NOTFOUND;
                                state_next = S_OUT;
                            end else begin
                                lo_next    = '0;
                                hi_next    = IW'(count_reg - 1'b1);
                                state_next = S_FIRST;
                            end
                        end
                        default: begin
                            ram_addr = IW'(s_slot_index);
                            if (CW'(s_slot_index) >= count_reg) begin
                                st_next    = sks_pkg::ST_RANGE;
                                state_next = S_OUT;
                            end else begin
                                pos_next   = '0;
                                mid_next   = IW'(s_slot_index);
                                state_next = S_CHILD;
                            end
                        end
                    endcase
                end
            end
            S_FIRST: begin
                if (sks_pkg::order_key(key_rd) > k_reg) begin
                    st_next    = sks_pkg::ST_NOTFOUND;
                    state_next = S_OUT;
                end else begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE: begin
                if (lo_reg < hi_reg) begin
                    mid_next   = mid_sum[IW:1];
                    ram_addr   = mid_sum[IW:1];
                    state_next = S_CMP;
                end else begin
                    ram_addr   = lo_reg;
                    pos_next   = sks_pkg::POS_W'(lo_reg);
                    state_next = S_CHILD;
                end
            end
            S_CMP: begin
                if (sks_pkg::order_key(key_rd) > k_reg) begin
                    hi_next = mid_reg - 1'b1;
                end else begin
                    lo_next = mid_reg;
                end
                state_next = S_PROBE;
            end
            S_CHILD: begin
                cout_next  = child_rd;
                state_next = S_OUT;
            end
            S_OUT: begin
                // wait for the output register to be free
                if (!valid_reg || m_ready) begin
                    valid_next     = 1'b1;
                    out_st_next    = st_reg;
                    out_pos_next   = pos_reg;
                    out_cout_next  = cout_reg;
                    out_count_next = COUNT_W'(count_reg);
                    out_full_next  = (count_reg >= CW'(sks_pkg::CAPACITY));
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        k_reg         <= k_next;
        st_reg        <= st_next;
        pos_reg       <= pos_next;
        cout_reg      <= cout_next;
        out_st_reg    <= out_st_next;
        out_pos_reg   <= out_pos_next;
        out_cout_reg  <= out_cout_next;
        out_count_reg <= out_count_next;
        out_full_reg  <= out_full_next;
    end
endmodule
